### rtl/core/rvlsu_pkg.sv
package rvlsu_pkg;

  localparam int MEM_BYTES_DEF = 65536;
  localparam int ADDR_W = 32;
  localparam int DATA_W = 32;

  localparam logic [2:0] F3_B  = 3'b000;
  localparam logic [2:0] F3_H  = 3'b001;
  localparam logic [2:0] F3_W  = 3'b010;
  localparam logic [2:0] F3_BU = 3'b100;
  localparam logic [2:0] F3_HU = 3'b101;

  localparam int FUNC_LOAD_BIT  = 0;
  localparam int FUNC_STORE_BIT = 1;

  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] store_value;
    logic [2:0]        load_width_code;
    logic [2:0]        store_width_code;
  } lsu_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              load_done;
    logic              store_done;
  } lsu_out_t;

  function automatic logic [2:0] load_bytes(input logic [2:0] code);
    logic [2:0] n;
    case (code)
      F3_B, F3_BU: n = 3'd1;
      F3_H, F3_HU: n = 3'd2;
      F3_W:        n = 3'd4;
      default:     n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] store_bytes(input logic [2:0] code);
    logic [2:0] n;
    case (code)
      F3_B:    n = 3'd1;
      F3_H:    n = 3'd2;
      F3_W:    n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

### rtl/core/rvlsu_addr_mod.sv
module rvlsu_addr_mod #(
  parameter int MEM_BYTES = rvlsu_pkg::MEM_BYTES_DEF,
  parameter int AW = $clog2(MEM_BYTES)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rvlsu_pkg::ADDR_W-1:0]  address,
  output logic                          done,
  output logic [AW-1:0]                 rem
);
  import rvlsu_pkg::*;

  // The quotient estimate from the reciprocal is the true quotient or one less,
  // so a single compare and subtract finishes the remainder.
  localparam logic [2*ADDR_W-1:0] ADDR_SPAN = (2*ADDR_W)'(64'h1_0000_0000);
  localparam logic [ADDR_W-1:0]   RECIP     = ADDR_W'(ADDR_SPAN / (2*ADDR_W)'(MEM_BYTES));
  localparam logic [AW:0]         MOD_VAL   = (AW + 1)'(MEM_BYTES);
  localparam logic [1:0]          STEP_END  = 2'd3;

  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [AW:0]         quo_r, quo_nxt;
  logic [AW:0]         qm_r, qm_nxt;
  logic [AW-1:0]       rem_r, rem_nxt;
  logic [1:0]          step_r, step_nxt;
  logic                run_r, run_nxt;
  logic [2*ADDR_W-1:0] prod_full;
  logic [2*AW+1:0]     qm_full;
  logic [AW:0]         diff;

  assign prod_full = (2*ADDR_W)'(addr_r) * (2*ADDR_W)'(RECIP);
  assign qm_full   = (2*AW+2)'(quo_r) * (2*AW+2)'(MOD_VAL);
  assign diff      = addr_r[AW:0] - qm_r;

  always_comb begin
    addr_nxt = addr_r;
    quo_nxt  = quo_r;
    qm_nxt   = qm_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    if (start) begin
      addr_nxt = address;
      step_nxt = '0;
      run_nxt  = 1'b1;
    end else if (run_r && (step_r != STEP_END)) begin
      step_nxt = step_r + 2'd1;
      case (step_r)
        2'd0: begin
          quo_nxt = prod_full[ADDR_W +: AW + 1];
        end
        2'd1: begin
          qm_nxt = qm_full[AW:0];
        end
        default: begin
          if (diff >= MOD_VAL) begin
            rem_nxt = AW'(diff - MOD_VAL);
          end else begin
            rem_nxt = diff[AW-1:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      run_r  <= 1'b0;
    end else begin
      step_r <= step_nxt;
      run_r  <= run_nxt;
    end
    addr_r <= addr_nxt;
    quo_r  <= quo_nxt;
    qm_r   <= qm_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = run_r && (step_r == STEP_END);
  assign rem  = rem_r;

endmodule

### rtl/core/rvlsu_byte_ram.sv
module rvlsu_byte_ram #(
  parameter int MEM_BYTES = rvlsu_pkg::MEM_BYTES_DEF,
  parameter int AW = $clog2(MEM_BYTES)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  import rvlsu_pkg::*;

  logic [7:0] mem_r [MEM_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/rv32_load_store_memory_unit.sv
// Channel   Ports                     Transfer when
// input     start, busy, in_item      start high and busy low at a rising edge
// result    out_valid, out_result     out_valid high, one cycle per item
//
// Each item passes through the address reduction modulo MEM_BYTES (S_MOD), then L byte
// reads (S_READ) and a drain state (S_DRAIN) when L is not zero, then S byte writes
// (S_WRITE) and the result strobe (S_DONE), where L is 0, 1, 2 or 4 bytes loaded and S
// is 0, 1, 2 or 4 bytes stored; busy is low again in the cycle after the strobe. The
// byte-wide memory, read and written at one shared address, moves one byte a cycle.
// Reset clears the sequencer only; memory contents stay undefined until written.
// The receiver cannot stall, so the result is shown for exactly one cycle.
module rv32_load_store_memory_unit #(
  parameter int MEM_BYTES = rvlsu_pkg::MEM_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rvlsu_pkg::lsu_in_t  in_item,
  output logic                out_valid,
  output rvlsu_pkg::lsu_out_t out_result
);
  import rvlsu_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MOD   = 6'b000010,
    S_READ  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } lsu_state_t;

  lsu_state_t    state_r, state_nxt;
  lsu_in_t       item_r, item_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [AW-1:0] ptr_inc;
  logic [2:0]    k_r, k_nxt;
  logic [2:0]    n_ld_r, n_ld_nxt;
  logic [2:0]    n_st_r, n_st_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [1:0]    rd_lane_r, rd_lane_nxt;
  logic [7:0]    bytes_r [4];

  logic          mod_start;
  logic          mod_done;
  logic [AW-1:0] mod_rem;
  logic          mem_we;
  logic          mem_re;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;
  logic [15:0]   half;
  logic [31:0]   load_val;

  rvlsu_addr_mod #(
    .MEM_BYTES(MEM_BYTES),
    .AW(AW)
  ) u_addr_mod (
    .clk(clk),
    .rst_n(rst_n),
    .start(mod_start),
    .address(in_item.address),
    .done(mod_done),
    .rem(mod_rem)
  );

  rvlsu_byte_ram #(
    .MEM_BYTES(MEM_BYTES),
    .AW(AW)
  ) u_byte_ram (
    .clk(clk),
    .we(mem_we),
    .waddr(ptr_r),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(ptr_r),
    .rdata(mem_rdata)
  );

  assign ptr_inc   = (ptr_r == LAST_ADDR) ? '0 : ptr_r + AW'(1);
  assign mem_wdata = item_r.store_value[8*k_r[1:0] +: 8];
  assign mem_we    = (state_r == S_WRITE);
  assign mem_re    = (state_r == S_READ);

  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    base_nxt    = base_r;
    ptr_nxt     = ptr_r;
    k_nxt       = k_r;
    n_ld_nxt    = n_ld_r;
    n_st_nxt    = n_st_r;
    rd_vld_nxt  = 1'b0;
    rd_lane_nxt = rd_lane_r;
    mod_start   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          mod_start = 1'b1;
          n_ld_nxt  = in_item.func[FUNC_LOAD_BIT] ? load_bytes(in_item.load_width_code)
                                                  : 3'd0;
          n_st_nxt  = in_item.func[FUNC_STORE_BIT] ? store_bytes(in_item.store_width_code)
                                                   : 3'd0;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          base_nxt = mod_rem;
          ptr_nxt  = mod_rem;
          k_nxt    = 3'd0;
          if (n_ld_r != 3'd0) begin
            state_nxt = S_READ;
          end else if (n_st_r != 3'd0) begin
            state_nxt = S_WRITE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_READ: begin
        rd_vld_nxt  = 1'b1;
        rd_lane_nxt = k_r[1:0];
        k_nxt       = k_r + 3'd1;
        ptr_nxt     = ptr_inc;
        if (k_r + 3'd1 == n_ld_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        ptr_nxt = base_r;
        k_nxt   = 3'd0;
        if (n_st_r != 3'd0) begin
          state_nxt = S_WRITE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WRITE: begin
        k_nxt   = k_r + 3'd1;
        ptr_nxt = ptr_inc;
        if (k_r + 3'd1 == n_st_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
    item_r    <= item_nxt;
    base_r    <= base_nxt;
    ptr_r     <= ptr_nxt;
    k_r       <= k_nxt;
    n_ld_r    <= n_ld_nxt;
    n_st_r    <= n_st_nxt;
    rd_lane_r <= rd_lane_nxt;
    if (rd_vld_r) begin
      bytes_r[rd_lane_r] <= mem_rdata;
    end
  end

  assign half = {bytes_r[1], bytes_r[0]};

  always_comb begin
    case (item_r.load_width_code)
      F3_B:    load_val = {{24{bytes_r[0][7]}}, bytes_r[0]};
      F3_BU:   load_val = {24'd0, bytes_r[0]};
      F3_H:    load_val = {{16{half[15]}}, half};
      F3_HU:   load_val = {16'd0, half};
      F3_W:    load_val = {bytes_r[3], bytes_r[2], half};
      default: load_val = '0;
    endcase
  end

  assign busy                  = (state_r != S_IDLE);
  assign out_valid             = (state_r == S_DONE);
  assign out_result.read_data  = item_r.func[FUNC_LOAD_BIT] ? load_val : '0;
  assign out_result.load_done  = item_r.func[FUNC_LOAD_BIT];
  assign out_result.store_done = (n_st_r != 3'd0);

endmodule

### dv/rv32_load_store_memory_unit_tb.sv
`timescale 1ns / 1ps

module rv32_load_store_memory_unit_tb;
  import rvlsu_pkg::*;

  localparam int MEM_BYTES = MEM_BYTES_DEF;
  localparam int RANDOM_REQUESTS = 1800;
  localparam int DRAIN_CYCLES = 60;

  localparam logic [1:0] FN_IDLE = 2'b00;
  localparam logic [1:0] FN_LOAD = 2'b01;
  localparam logic [1:0] FN_STORE = 2'b10;
  localparam logic [1:0] FN_LOAD_STORE = 2'b11;

  localparam logic [2:0] F3_NONE_LO = 3'b011;
  localparam logic [2:0] F3_NONE_MID = 3'b110;
  localparam logic [2:0] F3_NONE_HI = 3'b111;

  class lsu_result_tracker;
    bit [7:0] mem_image [MEM_BYTES];
    bit written [MEM_BYTES];
    int unsigned written_list[$];
    lsu_out_t pending_results[$];
    int unsigned error_count;

    function int unsigned wrap_index(logic [31:0] base, int unsigned k);
      logic [32:0] sum;
      sum = {1'b0, base} + 33'(k);
      return int'(sum % MEM_BYTES);
    endfunction

    function lsu_out_t predict_access(lsu_in_t req);
      lsu_out_t res;
      logic [7:0] b0, b1, b2, b3;
      logic [15:0] half;
      int unsigned n;
      int unsigned idx;
      res = '0;
      if (req.func[FUNC_LOAD_BIT]) begin
        b0 = mem_image[wrap_index(req.address, 0)];
        b1 = mem_image[wrap_index(req.address, 1)];
        b2 = mem_image[wrap_index(req.address, 2)];
        b3 = mem_image[wrap_index(req.address, 3)];
        half = {b1, b0};
        case (req.load_width_code)
          F3_B: res.read_data = {{24{b0[7]}}, b0};
          F3_BU: res.read_data = {24'b0, b0};
          F3_H: res.read_data = {{16{half[15]}}, half};
          F3_HU: res.read_data = {16'b0, half};
          F3_W: res.read_data = {b3, b2, b1, b0};
          default: res.read_data = '0;
        endcase
        res.load_done = 1'b1;
      end
      if (req.func[FUNC_STORE_BIT]) begin
        case (req.store_width_code)
          F3_B: n = 1;
          F3_H: n = 2;
          F3_W: n = 4;
          default: n = 0;
        endcase
        for (int k = 0; k < n; k++) begin
          idx = wrap_index(req.address, k);
          mem_image[idx] = req.store_value[8*k +: 8];
          if (!written[idx]) begin
            written[idx] = 1'b1;
            written_list.push_back(idx);
          end
        end
        res.store_done = (n != 0);
      end
      return res;
    endfunction

    function void note_request(lsu_in_t req);
      pending_results.push_back(predict_access(req));
    endfunction

    function void check_result(lsu_out_t got);
      lsu_out_t want;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("Unexpected result with nothing pending: got %h", got);
        return;
      end
      want = pending_results.pop_front();
      if (got.read_data !== want.read_data || got.load_done !== want.load_done ||
          got.store_done !== want.store_done) begin
        error_count++;
        if (error_count <= 10)
          $display("Result mismatch: read_data exp %h got %h, load_done exp %b got %b, store_done exp %b got %b",
                   want.read_data, got.read_data, want.load_done, got.load_done,
                   want.store_done, got.store_done);
      end
    endfunction

    function bit find_readable(int unsigned n, output logic [31:0] base);
      int unsigned w;
      bit ok;
      w = 0;
      for (int t = 0; t < 8; t++) begin
        w = written_list[$urandom_range(0, written_list.size() - 1)];
        base = wrap_index(w, MEM_BYTES - $urandom_range(0, n - 1));
        ok = 1'b1;
        for (int k = 0; k < n; k++)
          if (!written[wrap_index(base, k)]) ok = 1'b0;
        if (ok) return 1'b1;
      end
      base = w;
      return 1'b0;
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  lsu_in_t in_item = '0;
  logic out_valid;
  lsu_out_t out_result;

  lsu_result_tracker tracker;
  bit burst;

  rv32_load_store_memory_unit #(
    .MEM_BYTES(MEM_BYTES)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_result(out_result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_result(out_result);
  end

  function automatic lsu_in_t make_request(logic [1:0] f, logic [31:0] addr,
                                           logic [31:0] value, logic [2:0] lcode,
                                           logic [2:0] scode);
    lsu_in_t req;
    req.func = f;
    req.address = addr;
    req.store_value = value;
    req.load_width_code = lcode;
    req.store_width_code = scode;
    return req;
  endfunction

  function automatic lsu_in_t random_request();
    lsu_in_t req;
    int unsigned r;
    int unsigned n;
    logic [31:0] base;
    logic [31:0] low;
    req.store_value = $urandom();
    case ($urandom_range(0, 3))
      0: req.store_width_code = F3_B;
      1: req.store_width_code = F3_H;
      2: req.store_width_code = F3_W;
      default: req.store_width_code = 3'($urandom_range(0, 7));
    endcase
    r = $urandom_range(0, 19);
    req.func = (r == 0) ? FN_IDLE : (r < 8) ? FN_LOAD : (r < 15) ? FN_STORE : FN_LOAD_STORE;
    req.load_width_code = 3'($urandom_range(0, 7));
    req.address = $urandom();
    if (req.func[FUNC_STORE_BIT]) begin
      r = $urandom_range(0, 9);
      if (r < 5) low = $urandom_range(0, 511);
      else if (r < 7) low = MEM_BYTES - 16 + $urandom_range(0, 15);
      else low = req.address & 32'(MEM_BYTES - 1);
      req.address = (req.address & ~32'(MEM_BYTES - 1)) | low;
    end
    if (req.func[FUNC_LOAD_BIT]) begin
      case (req.load_width_code)
        F3_B, F3_BU: n = 1;
        F3_H, F3_HU: n = 2;
        F3_W: n = 4;
        default: n = 0;
      endcase
      if (n != 0) begin
        if (!tracker.find_readable(n, base)) req.load_width_code = F3_BU;
        req.address = (req.address & ~32'(MEM_BYTES - 1)) | base;
      end
    end
    return req;
  endfunction

  task automatic send_request(input lsu_in_t req);
    int unsigned gap;
    bit after_ready;
    gap = burst ? 0 : $urandom_range(0, 14);
    after_ready = $urandom_range(0, 1);
    in_item <= req;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    tracker.note_request(req);
    if (gap != 0) begin
      start <= 1'b0;
      if (after_ready) begin
        do @(posedge clk); while (busy);
      end
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_directed();
    send_request(make_request(FN_STORE, 32'h0000_0000, 32'h8081_8283, F3_B, F3_W));
    send_request(make_request(FN_LOAD, 32'h0000_0000, 32'h0, F3_W, F3_B));
    send_request(make_request(FN_LOAD, 32'h0000_0000, 32'h0, F3_B, F3_B));
    send_request(make_request(FN_LOAD, 32'h0000_0000, 32'h0, F3_BU, F3_B));
    send_request(make_request(FN_LOAD, 32'h0000_0000, 32'h0, F3_H, F3_B));
    send_request(make_request(FN_LOAD, 32'h0000_0000, 32'h0, F3_HU, F3_B));
    send_request(make_request(FN_LOAD, 32'h0000_0003, 32'h0, F3_B, F3_B));
    send_request(make_request(FN_LOAD, 32'h0000_0002, 32'h0, F3_HU, F3_B));
    send_request(make_request(FN_STORE, 32'hFFFF_FFFE, 32'h7F6E_5D4C, F3_B, F3_W));
    send_request(make_request(FN_LOAD, 32'hFFFF_FFFE, 32'h0, F3_W, F3_B));
    send_request(make_request(FN_LOAD, 32'h0001_FFFF, 32'h0, F3_H, F3_B));
    send_request(make_request(FN_STORE, 32'h1234_0010, 32'hFFFF_FF7F, F3_B, F3_B));
    send_request(make_request(FN_STORE, 32'hABCD_0011, 32'h0000_8001, F3_B, F3_H));
    send_request(make_request(FN_LOAD, 32'h0000_0011, 32'h0, F3_HU, F3_B));
    send_request(make_request(FN_LOAD, 32'h0001_0010, 32'h0, F3_B, F3_B));
    send_request(make_request(FN_LOAD_STORE, 32'h0000_0000, 32'hFFFF_FFFF, F3_W, F3_W));
    send_request(make_request(FN_LOAD, 32'h0000_0000, 32'h0, F3_W, F3_B));
    send_request(make_request(FN_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, F3_B, F3_NONE_HI));
    send_request(make_request(FN_LOAD, 32'hFFFF_FFFF, 32'h0, F3_W, F3_B));
    send_request(make_request(FN_LOAD, 32'h5555_AAAA, 32'h0, F3_NONE_LO, F3_B));
    send_request(make_request(FN_LOAD, 32'hFFFF_FFFF, 32'h0, F3_NONE_MID, F3_B));
    send_request(make_request(FN_LOAD, 32'h0000_7777, 32'h0, F3_NONE_HI, F3_B));
    send_request(make_request(FN_IDLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, F3_NONE_HI, F3_NONE_HI));
    send_request(make_request(FN_LOAD_STORE, 32'h0000_0000, 32'h0000_0000, F3_NONE_LO, F3_B));
    send_request(make_request(FN_LOAD_STORE, 32'h0000_0000, 32'h1234_5678, F3_W, F3_NONE_LO));
  endtask

  initial begin
    tracker = new();
    burst = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if ($urandom_range(0, 99) == 0) burst = !burst;
      send_request(random_request());
    end
    start <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.error_count == 0 && tracker.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
